@@ src/kvt_pkg.sv @@
// kvt_pkg: shared constants, operation codes, state encoding and structs
// for the key/value table. No dependencies.

package kvt_pkg;

  // table geometry
  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;

  // derived widths
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = 9;  // holds positions, counts and the capacity register

  // fixed field widths of the transaction payloads
  localparam int OP_W    = 3;
  localparam int WORD_W  = 64;
  localparam int POS_W   = 8;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_UPSERT  = 3'd2,
    OP_ERASE   = 3'd3,
    OP_GET_KEY = 3'd4,
    OP_GET_POS = 3'd5
  } kvt_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_APPLY,
    ST_RESP
  } kvt_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] lookup_key;
    logic [WORD_W-1:0] new_value;
    logic [POS_W-1:0]  position;
  } kvt_req_t;

  typedef struct packed {
    logic               success;
    logic [WORD_W-1:0]  key_out;
    logic [WORD_W-1:0]  value_out;
    logic [COUNT_W-1:0] entry_count;
  } kvt_resp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } kvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
  } kvt_status_t;

endpackage

@@ src/key_value_table.sv @@
// key_value_table: top level of the bounded key/value table.
// Each request runs scan, read, apply and response states; the scan reads one key per cycle
//   over all live entries on a miss, fewer on an early hit, none for get by position.
// A new request is taken only in idle, after the last response is accepted.
// Reset (synchronous, rst high): empty table, capacity 16; stores not cleared.
// Depends on kvt_pkg, kvt_ctrl and kvt_datapath.

module key_value_table
  import kvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  kvt_req_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output kvt_resp_t        out_data,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  kvt_cmd_t    cmd;
  kvt_status_t status;

  // sequencer
  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // stores and arithmetic
  kvt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

@@ src/kvt_ctrl.sv @@
// kvt_ctrl: sequencing state machine for the key/value table.
// Depends on kvt_pkg.

module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_stall,
  input  kvt_status_t status,
  output kvt_cmd_t    cmd,
  output logic        in_stall,
  output logic        out_valid
);

  kvt_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_end) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_RESP;
      ST_RESP: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.scan = 1'b1;
      ST_READ:  ;
      ST_APPLY: cmd.apply = 1'b1;
      ST_RESP:  out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

@@ src/kvt_datapath.sv @@
// kvt_datapath: request register, key/value stores, scan pointer, live count,
// capacity register and result register. Depends on kvt_pkg.

module kvt_datapath
  import kvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  kvt_cmd_t         cmd,
  input  kvt_req_t         in_data,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata,
  output kvt_status_t      status,
  output kvt_resp_t        out_data
);

  // entry stores
  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

  // request and control registers
  kvt_op_t                op;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [POS_W-1:0]       req_pos;
  logic [CNT_W-1:0]       count, count_next;
  logic [CFG_W-1:0]       cap;
  logic [CNT_W-1:0]       idx;
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [VALUE_WIDTH-1:0] hit_val;
  kvt_resp_t              result;

  // combinational
  logic                   match;
  logic                   needs_scan;
  logic                   exhausted;
  logic [CNT_W-1:0]       last_idx;
  logic [IDX_W-1:0]       raddr;
  logic [CMP_W-1:0]       room;
  logic                   wr_en_k;
  logic                   wr_en_v;
  logic [IDX_W-1:0]       wr_addr;
  logic [KEY_WIDTH-1:0]   wr_k;
  logic [VALUE_WIDTH-1:0] wr_v;
  logic                   ok;
  logic [KEY_WIDTH-1:0]   kout;
  logic [VALUE_WIDTH-1:0] vout;

  // scan status
  assign match      = rd_valid && (rd_key == req_key);
  assign needs_scan = (op == OP_INSERT) || (op == OP_UPDATE) || (op == OP_UPSERT) ||
                      (op == OP_ERASE) || (op == OP_GET_KEY);
  assign exhausted  = (idx >= count) && !rd_valid;
  assign status.scan_end = !needs_scan || match || exhausted;

  // effective capacity, clipped to the store depth
  assign room = (CMP_W'(cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap);

  // position of the last live entry
  assign last_idx = CNT_W'(count - CNT_W'(1));

  // read address: scan pointer, last entry for erase, or requested position
  always_comb begin
    if (cmd.scan) begin
      raddr = idx[IDX_W-1:0];
    end else if (op == OP_ERASE) begin
      raddr = last_idx[IDX_W-1:0];
    end else begin
      raddr = req_pos[IDX_W-1:0];
    end
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[raddr];
    rd_val  <= val_mem[raddr];
    rd_addr <= raddr;
  end

  // store write port
  always_ff @(posedge clk) begin
    if (wr_en_k) key_mem[wr_addr] <= wr_k;
    if (wr_en_v) val_mem[wr_addr] <= wr_v;
  end

  // operation decode on the apply step
  always_comb begin
    wr_en_k    = 1'b0;
    wr_en_v    = 1'b0;
    wr_addr    = hit_idx;
    wr_k       = req_key;
    wr_v       = req_val;
    ok         = 1'b0;
    kout       = '0;
    vout       = '0;
    count_next = count;
    case (op)
      OP_INSERT, OP_UPDATE, OP_UPSERT: begin
        if (found) begin
          if (op != OP_INSERT) begin
            wr_en_v = cmd.apply;
            ok      = 1'b1;
          end
        end else if (op != OP_UPDATE && CMP_W'(count) < room) begin
          wr_en_k    = cmd.apply;
          wr_en_v    = cmd.apply;
          wr_addr    = count[IDX_W-1:0];
          ok         = 1'b1;
          count_next = CNT_W'(count + CNT_W'(1));
        end
      end
      OP_ERASE: begin
        // last entry fills the hole
        if (found) begin
          wr_en_k    = cmd.apply;
          wr_en_v    = cmd.apply;
          wr_k       = rd_key;
          wr_v       = rd_val;
          ok         = 1'b1;
          count_next = CNT_W'(count - CNT_W'(1));
        end
      end
      OP_GET_KEY: begin
        if (found) begin
          ok   = 1'b1;
          vout = hit_val;
        end
      end
      OP_GET_POS: begin
        if (CMP_W'(req_pos) < CMP_W'(count)) begin
          ok   = 1'b1;
          kout = rd_key;
          vout = rd_val;
        end
      end
      default: ;
    endcase
  end

  // request capture, scan pointer and match tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= kvt_op_t'(in_data.operation);
      req_key <= in_data.lookup_key[KEY_WIDTH-1:0];
      req_val <= in_data.new_value[VALUE_WIDTH-1:0];
      req_pos <= in_data.position;
      idx     <= '0;
      found   <= 1'b0;
    end else if (cmd.scan) begin
      if (idx < count) idx <= CNT_W'(idx + CNT_W'(1));
      if (match && !found) begin
        found   <= 1'b1;
        hit_idx <= rd_addr;
        hit_val <= rd_val;
      end
    end
  end

  // read-in-flight flag for the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan && (idx < count) && !match;
    end
  end

  // live count and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CFG_W'(16);
    end else begin
      if (cmd.apply) count <= count_next;
      if (cfg_wen)   cap   <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      result.success     <= ok;
      result.key_out     <= WORD_W'(kout);
      result.value_out   <= WORD_W'(vout);
      result.entry_count <= COUNT_W'(count_next);
    end
  end

  assign out_data = result;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("live count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |=> count == $past(count))
    else $error("live count changed outside apply");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en_k || wr_en_v) |-> CMP_W'(wr_addr) <= CMP_W'(count))
    else $error("store write beyond live entries");

  a_scan_one_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && found) |-> !rd_valid)
    else $error("scan still reading after a hit");

endmodule
